// ===== design/sisg_pkg.sv =====
`timescale 1ns / 1ps
package sisg_pkg;

  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_MAX_EDGES = 4096;

  localparam int CMD_W      = 2;
  localparam int NODE_F_W   = 10;
  localparam int EDGE_F_W   = 12;
  localparam int U_W        = 32;
  localparam int RATE_W     = 32;
  localparam int DT_W       = 48;
  localparam int NR_OUT_W   = 11;
  localparam int NI_OUT_W   = 13;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;

  // -ln(u) in Q.32 needs at most 38 bits; dt numerator is that shifted by 8
  localparam int LN_W       = 38;
  localparam int DT_SHIFT   = 8;
  localparam int NUM_W      = LN_W + DT_SHIFT;

  localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

  localparam logic [RATE_W-1:0] RATE_RESET       = 32'h0100_0000;
  localparam logic [10:0]       NODE_COUNT_RESET = 11'd1024;
  localparam logic [12:0]       EDGE_COUNT_RESET = 13'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_EDGE = 2'd0,
    CMD_WRITE_NODE = 2'd1,
    CMD_STEP       = 2'd2,
    CMD_FLIP       = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INFECTION_RATE = 2'd0,
    CFG_RECOVERY_RATE  = 2'd1,
    CFG_NODE_COUNT     = 2'd2,
    CFG_EDGE_COUNT     = 2'd3
  } cfg_idx_t;

endpackage

// ===== design/sisg_if.sv =====
`timescale 1ns / 1ps
interface sisg_req_if import sisg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [NODE_F_W-1:0] node_index;
  logic                node_infected;
  logic [EDGE_F_W-1:0] edge_index;
  logic [NODE_F_W-1:0] end_first;
  logic [NODE_F_W-1:0] end_second;
  logic [U_W-1:0]      uniform_event;
  logic [U_W-1:0]      uniform_pick;
  logic [U_W-1:0]      uniform_time;

  modport source (output valid, command, node_index, node_infected, edge_index,
                  end_first, end_second, uniform_event, uniform_pick, uniform_time,
                  input ready);
  modport sink   (input valid, command, node_index, node_infected, edge_index,
                  end_first, end_second, uniform_event, uniform_pick, uniform_time,
                  output ready);
endinterface

interface sisg_rsp_if import sisg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                has_proposal;
  logic                event_kind;
  logic [NODE_F_W-1:0] proposed_node;
  logic [DT_W-1:0]     time_step;
  logic [NR_OUT_W-1:0] infected_total;
  logic [NI_OUT_W-1:0] active_edges;

  modport source (output valid, has_proposal, event_kind, proposed_node, time_step,
                  infected_total, active_edges, input ready);
  modport sink   (input valid, has_proposal, event_kind, proposed_node, time_step,
                  infected_total, active_edges, output ready);
endinterface

// ===== design/sisg_neg_ln.sv =====
`timescale 1ns / 1ps
module sisg_neg_ln import sisg_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [U_W-1:0]  u,
  output logic            done,
  output logic [LN_W-1:0] q
);

  typedef enum logic [2:0] {L_IDLE, L_NORM, L_SQ, L_M0, L_M1} ln_state_t;

  ln_state_t   state;
  logic [31:0] x;
  logic [4:0]  e;
  logic [31:0] frac;
  logic [4:0]  bit_idx;
  logic [31:0] p0_hi;
  logic [31:0] ma, mb;
  logic [63:0] mul;
  logic [32:0] sq;
  logic [37:0] nl2;

  // 32 - log2(u) with integer part e and 32 fraction bits
  assign nl2 = {1'b1, 37'd0} - {1'b0, e, frac};
  assign mul = 64'(ma) * 64'(mb);
  assign sq  = mul[63:31];

  always_comb begin
    ma = x;
    mb = x;
    case (state)
      L_M0: begin
        ma = nl2[31:0];
        mb = LN2_Q32;
      end
      L_M1: begin
        ma = 32'(nl2[37:32]);
        mb = LN2_Q32;
      end
      default: begin
        ma = x;
        mb = x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (start) begin
            x     <= u;
            e     <= 5'd31;
            state <= L_NORM;
          end
        end
        L_NORM: begin
          // one bit of the leading-one search per cycle
          if (x[31] || e == 5'd0) begin
            bit_idx <= 5'd31;
            frac    <= '0;
            state   <= L_SQ;
          end else begin
            x <= x << 1;
            e <= e - 5'd1;
          end
        end
        L_SQ: begin
          if (sq[32]) begin
            x             <= sq[32:1];
            frac[bit_idx] <= 1'b1;
          end else begin
            x <= sq[31:0];
          end
          if (bit_idx == 5'd0) state <= L_M0;
          else bit_idx <= bit_idx - 5'd1;
        end
        L_M0: begin
          p0_hi <= mul[63:32];
          state <= L_M1;
        end
        L_M1: begin
          q     <= LN_W'(mul + 64'(p0_hi));
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

// ===== design/sisg_divider.sv =====
`timescale 1ns / 1ps
module sisg_divider import sisg_pkg::*; #(
  parameter int DEN_W = 46
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [LN_W-1:0]  ln_in,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);

  typedef enum logic {D_IDLE, D_RUN} div_state_t;

  div_state_t       state;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // restoring division, one quotient bit per cycle shifted into quo
  assign trial = {rem, quo[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            quo   <= {ln_in, DT_SHIFT'(0)};
            rem   <= '0;
            den_r <= den;
            cnt   <= CNT_W'(NUM_W - 1);
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], ge};
          if (cnt == '0) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== design/sis_network_gillespie_step.sv =====
// SIS epidemic on a graph, one Gillespie event proposal per step command.
// req channel (valid/ready) carries commands: write edge, write node state,
// step, flip node. Every accepted item gives exactly one item on rsp; for
// everything but a step all result fields are zero.
// cfg_we/cfg_index/cfg_data write the rates and node/edge counts; write only
// while no item is in flight.
// Edge writes and node writes go from idle straight to the result state; a
// flip first passes a node memory read state and a write state. A step scans
// the nodes in use, then the edges in use, then, if an event is possible,
// makes a candidate pass over nodes (recovery) or edges (infection): the
// scans go one entry a cycle through the edge memory and the two read ports
// of the node memory, then come the bit-serial log and the divider.
// One item is worked on at a time; req.ready is low while it is busy.
// After reset the node memory is swept to all susceptible, one node a cycle;
// req.ready stays low meanwhile, config writes are taken.
// While an earlier result still waits for rsp.ready, the finished result is
// held and the block waits before returning to idle.
`timescale 1ns / 1ps
module sis_network_gillespie_step import sisg_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_EDGES = DEF_MAX_EDGES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  sisg_req_if.sink             req,
  sisg_rsp_if.source           rsp
);

  localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int EDGE_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int NR_W   = $clog2(MAX_NODES + 1);
  localparam int NI_W   = $clog2(MAX_EDGES + 1);
  localparam int SC_W   = (NR_W > NI_W) ? NR_W : NI_W;
  localparam int WR_W   = NR_W + RATE_W;
  localparam int WI_W   = NI_W + RATE_W;
  localparam int TOT_W  = ((WR_W > WI_W) ? WR_W : WI_W) + 1;
  localparam int CMP_W  = TOT_W + U_W;
  localparam int ED_W   = 2 * NODE_F_W;

  typedef enum logic [4:0] {
    S_IDLE, S_FLIP_RD, S_FLIP_WR, S_NSCAN, S_ESCAN, S_MULR, S_MULI, S_TOT,
    S_CHK, S_CMP1, S_KIND, S_KMUL, S_KSET, S_LN_GO, S_LN_WAIT, S_DIV_GO,
    S_DIV_WAIT, S_DONE
  } state_t;

  // configuration
  logic [RATE_W-1:0] infection_rate, recovery_rate;
  logic [10:0]       node_count;
  logic [12:0]       edge_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      infection_rate <= RATE_RESET;
      recovery_rate  <= RATE_RESET;
      node_count     <= NODE_COUNT_RESET;
      edge_count     <= EDGE_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_INFECTION_RATE: infection_rate <= cfg_data;
        CFG_RECOVERY_RATE:  recovery_rate  <= cfg_data;
        CFG_NODE_COUNT:     node_count     <= cfg_data[10:0];
        CFG_EDGE_COUNT:     edge_count     <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  logic [SC_W-1:0] nn_s, ne_s;

  always_comb begin
    if (32'(node_count) < 32'(MAX_NODES)) nn_s = SC_W'(node_count);
    else nn_s = SC_W'(MAX_NODES);
    if (32'(edge_count) < 32'(MAX_EDGES)) ne_s = SC_W'(edge_count);
    else ne_s = SC_W'(MAX_EDGES);
  end

  // control and datapath registers
  state_t              state;
  logic                clr_active;
  logic [NODE_W-1:0]   clr_addr;
  logic                pick, found;
  logic [SC_W-1:0]     idx, idx1;
  logic                v1, v2;
  logic [NODE_F_W-1:0] ea2, eb2;
  logic                ra2, rb2;
  logic [NR_W-1:0]     nr;
  logic [NI_W-1:0]     ni;
  logic [WR_W-1:0]     wr;
  logic [TOT_W-1:0]    total;
  logic [63:0]         prod, p0;
  logic [SC_W-1:0]     k;
  logic [NODE_W-1:0]   nidx_a;
  logic [U_W-1:0]      ue_r, up_r, ut_r;

  logic                res_has, res_kind;
  logic [NODE_F_W-1:0] res_node;
  logic [DT_W-1:0]     res_dt;
  logic [NR_OUT_W-1:0] res_nr;
  logic [NI_OUT_W-1:0] res_ni;

  logic                o_valid, o_has, o_kind;
  logic [NODE_F_W-1:0] o_node;
  logic [DT_W-1:0]     o_dt;
  logic [NR_OUT_W-1:0] o_nr;
  logic [NI_OUT_W-1:0] o_ni;

  // memories
  logic              node_mem [MAX_NODES];
  logic [ED_W-1:0]   edge_mem [MAX_EDGES];
  logic              rd_a, rd_b;
  logic [ED_W-1:0]   ed;
  logic [NODE_W-1:0] raddr_a, raddr_b, nwaddr;
  logic              nwe, nwdata;
  logic              ewe;
  logic [EDGE_W-1:0] ewaddr, eraddr;

  logic       accept;
  cmd_t       cmd_in;
  logic       node_in_ok, edge_in_ok, end_a_ok, end_b_ok;
  logic       issue_n, issue_e;
  logic       sa, sb, act;
  logic [31:0] ma, mb;
  logic [CMP_W-1:0] cmp_l, cmp_r;
  logic        ln_done, div_done;
  logic [LN_W-1:0]  ln_q;
  logic [NUM_W-1:0] quo;
  logic [U_W-1:0]   ln_u;

  assign req.ready = (state == S_IDLE) && !clr_active;
  assign accept    = req.valid && req.ready;
  assign cmd_in    = cmd_t'(req.command);

  assign node_in_ok = 32'(req.node_index) < 32'(MAX_NODES);
  assign edge_in_ok = 32'(req.edge_index) < 32'(MAX_EDGES);
  assign end_a_ok   = 32'(ed[ED_W-1:NODE_F_W]) < 32'(MAX_NODES);
  assign end_b_ok   = 32'(ed[NODE_F_W-1:0]) < 32'(MAX_NODES);

  assign issue_n = idx < nn_s;
  assign issue_e = idx < ne_s;
  assign sa      = rd_a & ra2;
  assign sb      = rd_b & rb2;
  assign act     = sa ^ sb;

  assign ewe    = accept && (cmd_in == CMD_WRITE_EDGE) && edge_in_ok;
  assign ewaddr = EDGE_W'(req.edge_index);
  assign eraddr = EDGE_W'(idx);

  always_comb begin
    raddr_a = NODE_W'(idx);
    case (state)
      S_ESCAN:   raddr_a = NODE_W'(ed[ED_W-1:NODE_F_W]);
      S_FLIP_RD: raddr_a = nidx_a;
      default:   raddr_a = NODE_W'(idx);
    endcase
    raddr_b = NODE_W'(ed[NODE_F_W-1:0]);
  end

  always_comb begin
    nwe    = 1'b0;
    nwaddr = clr_addr;
    nwdata = 1'b0;
    if (clr_active) begin
      nwe = 1'b1;
    end else if (state == S_FLIP_WR) begin
      nwe    = 1'b1;
      nwaddr = nidx_a;
      nwdata = ~rd_a;
    end else if (accept && cmd_in == CMD_WRITE_NODE && node_in_ok) begin
      nwe    = 1'b1;
      nwaddr = NODE_W'(req.node_index);
      nwdata = req.node_infected;
    end
  end

  always_ff @(posedge clk) begin
    if (nwe) node_mem[nwaddr] <= nwdata;
    rd_a <= node_mem[raddr_a];
    rd_b <= node_mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (ewe) edge_mem[ewaddr] <= {req.end_first, req.end_second};
    ed <= edge_mem[eraddr];
  end

  // shared 32x32 multiplier, product registered
  always_comb begin
    ma = 32'(nr);
    mb = recovery_rate;
    case (state)
      S_MULI: begin
        ma = 32'(ni);
        mb = infection_rate;
      end
      S_CHK: begin
        ma = total[31:0];
        mb = ue_r;
      end
      S_CMP1: begin
        ma = 32'(total >> 32);
        mb = ue_r;
      end
      S_KMUL: begin
        ma = res_kind ? 32'(ni) : 32'(nr);
        mb = up_r;
      end
      default: begin
        ma = 32'(nr);
        mb = recovery_rate;
      end
    endcase
  end

  // recovery iff wr*2^32 > total*uniform_event
  assign cmp_l = CMP_W'({wr, 32'd0});
  assign cmp_r = CMP_W'(p0) + (CMP_W'(prod) << 32);
  assign ln_u  = (ut_r == '0) ? U_W'(1) : ut_r;

  sisg_neg_ln u_neg_ln (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_LN_GO),
    .u     (ln_u),
    .done  (ln_done),
    .q     (ln_q)
  );

  sisg_divider #(.DEN_W(TOT_W)) u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIV_GO),
    .ln_in (ln_q),
    .den   (total),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      clr_active <= 1'b1;
      clr_addr   <= '0;
      o_valid    <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
    end else begin
      prod <= 64'(ma) * 64'(mb);
      v1   <= 1'b0;
      v2   <= 1'b0;

      if (clr_active) begin
        if (clr_addr == NODE_W'(MAX_NODES - 1)) clr_active <= 1'b0;
        else clr_addr <= clr_addr + NODE_W'(1);
      end

      if (o_valid && rsp.ready) o_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (accept) begin
            nidx_a   <= NODE_W'(req.node_index);
            ue_r     <= req.uniform_event;
            up_r     <= req.uniform_pick;
            ut_r     <= req.uniform_time;
            res_has  <= 1'b0;
            res_kind <= 1'b0;
            res_node <= '0;
            res_dt   <= '0;
            res_nr   <= '0;
            res_ni   <= '0;
            nr       <= '0;
            ni       <= '0;
            pick     <= 1'b0;
            found    <= 1'b0;
            idx      <= '0;
            case (cmd_in)
              CMD_STEP: state <= S_NSCAN;
              CMD_FLIP: state <= node_in_ok ? S_FLIP_RD : S_DONE;
              default:  state <= S_DONE;
            endcase
          end
        end
        S_FLIP_RD: state <= S_FLIP_WR;
        S_FLIP_WR: state <= S_DONE;
        S_NSCAN: begin
          v1   <= issue_n;
          idx1 <= idx;
          if (issue_n) idx <= idx + SC_W'(1);
          if (v1) begin
            if (!pick) begin
              nr <= nr + NR_W'(rd_a);
            end else if (rd_a && !found) begin
              if (k == '0) begin
                found    <= 1'b1;
                res_node <= NODE_F_W'(idx1);
              end else begin
                k <= k - SC_W'(1);
              end
            end
          end
          if (!issue_n && !v1) begin
            idx   <= '0;
            state <= pick ? S_LN_GO : S_ESCAN;
          end
        end
        S_ESCAN: begin
          // edge read, then both endpoint reads, then count or pick
          v1  <= issue_e;
          v2  <= v1;
          ea2 <= ed[ED_W-1:NODE_F_W];
          eb2 <= ed[NODE_F_W-1:0];
          ra2 <= end_a_ok;
          rb2 <= end_b_ok;
          if (issue_e) idx <= idx + SC_W'(1);
          if (v2) begin
            if (!pick) begin
              ni <= ni + NI_W'(act);
            end else if (act && !found) begin
              if (k == '0) begin
                found    <= 1'b1;
                res_node <= sa ? eb2 : ea2;
              end else begin
                k <= k - SC_W'(1);
              end
            end
          end
          if (!issue_e && !v1 && !v2) state <= pick ? S_LN_GO : S_MULR;
        end
        S_MULR: state <= S_MULI;
        S_MULI: begin
          wr    <= prod[WR_W-1:0];
          state <= S_TOT;
        end
        S_TOT: begin
          total  <= TOT_W'(wr) + TOT_W'(prod[WI_W-1:0]);
          res_nr <= NR_OUT_W'(nr);
          res_ni <= NI_OUT_W'(ni);
          state  <= S_CHK;
        end
        S_CHK: begin
          if (nr == '0 || total == '0) begin
            res_dt <= '1;
            state  <= S_DONE;
          end else begin
            state <= S_CMP1;
          end
        end
        S_CMP1: begin
          p0    <= prod;
          state <= S_KIND;
        end
        S_KIND: begin
          res_kind <= !(cmp_l > cmp_r);
          state    <= S_KMUL;
        end
        S_KMUL: state <= S_KSET;
        S_KSET: begin
          k     <= SC_W'(prod[63:32]);
          pick  <= 1'b1;
          found <= 1'b0;
          idx   <= '0;
          state <= res_kind ? S_ESCAN : S_NSCAN;
        end
        S_LN_GO: state <= S_LN_WAIT;
        S_LN_WAIT: if (ln_done) state <= S_DIV_GO;
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            // quotient stays below 2^46, so it never reaches saturation
            res_dt  <= DT_W'(quo);
            res_has <= 1'b1;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!o_valid || rsp.ready) begin
            o_valid <= 1'b1;
            o_has   <= res_has;
            o_kind  <= res_kind;
            o_node  <= res_node;
            o_dt    <= res_dt;
            o_nr    <= res_nr;
            o_ni    <= res_ni;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid          = o_valid;
  assign rsp.has_proposal   = o_has;
  assign rsp.event_kind     = o_kind;
  assign rsp.proposed_node  = o_node;
  assign rsp.time_step      = o_dt;
  assign rsp.infected_total = o_nr;
  assign rsp.active_edges   = o_ni;

endmodule

// ===== dv/sis_network_gillespie_step_test.sv =====
`timescale 1ns / 1ps
module sis_network_gillespie_step_test;
  import sisg_pkg::*;

  typedef struct {
    cmd_t                command;
    logic [NODE_F_W-1:0] node_index;
    logic                node_infected;
    logic [EDGE_F_W-1:0] edge_index;
    logic [NODE_F_W-1:0] end_first;
    logic [NODE_F_W-1:0] end_second;
    logic [U_W-1:0]      uniform_event;
    logic [U_W-1:0]      uniform_pick;
    logic [U_W-1:0]      uniform_time;
  } sis_cmd_t;

  typedef struct {
    logic                has_proposal;
    logic                event_kind;
    logic [NODE_F_W-1:0] proposed_node;
    logic [DT_W-1:0]     time_step;
    logic [NR_OUT_W-1:0] infected_total;
    logic [NI_OUT_W-1:0] active_edges;
  } proposal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  sisg_req_if req ();
  sisg_rsp_if rsp ();

  sis_network_gillespie_step u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req.sink), .rsp(rsp.source)
  );

  always #5 clk = ~clk;

  sis_cmd_t  cmd_queue[$];
  proposal_t proposal_queue[$];
  sis_cmd_t  cur_cmd;
  int        src_idle = 20;
  int        snk_idle = 52;
  bit        hold_req = 1'b0;
  bit        hold_done = 1'b0;
  int        hold_cnt = 0;
  int        errors = 0;

  // shadow of the block
  logic [DEF_MAX_NODES-1:0] node_st;
  logic [NODE_F_W-1:0]      edge_a[DEF_MAX_EDGES];
  logic [NODE_F_W-1:0]      edge_b[DEF_MAX_EDGES];
  logic [31:0]              alpha_q, gamma_q;
  logic [10:0]              nodes_cfg;
  logic [12:0]              edges_cfg;

  function automatic logic [63:0] neg_ln(logic [31:0] u);
    int e;
    logic [63:0] x, frac, nl2;
    logic [127:0] prod;
    e = 31;
    frac = '0;
    while (e > 0 && u[e] == 1'b0) e--;
    x = {32'd0, u} << (31 - e);
    for (int i = 31; i >= 0; i--) begin
      x = (x * x) >> 31;
      if (x >= 64'h1_0000_0000) begin
        x = x >> 1;
        frac[i] = 1'b1;
      end
    end
    nl2 = (64'd32 << 32) - ((64'(e) << 32) | frac);
    prod = {64'd0, nl2} * {96'd0, LN2_Q32};
    return prod[95:32];
  endfunction

  function automatic bit st(logic [NODE_F_W-1:0] n);
    return node_st[n];
  endfunction

  function automatic proposal_t apply_command(sis_cmd_t c);
    proposal_t   r;
    int          nn, ne;
    logic [63:0] nr, ni, wr, total, k, q, dt;
    logic [127:0] lhs, rhs;
    logic [31:0] ut;
    r = '{default: '0};
    case (c.command)
      CMD_WRITE_EDGE: begin
        edge_a[c.edge_index] = c.end_first;
        edge_b[c.edge_index] = c.end_second;
      end
      CMD_WRITE_NODE: node_st[c.node_index] = c.node_infected;
      CMD_FLIP:       node_st[c.node_index] = ~node_st[c.node_index];
      default: begin
        nn = int'(nodes_cfg) < DEF_MAX_NODES ? int'(nodes_cfg) : DEF_MAX_NODES;
        ne = int'(edges_cfg) < DEF_MAX_EDGES ? int'(edges_cfg) : DEF_MAX_EDGES;
        nr = 0;
        ni = 0;
        for (int i = 0; i < nn; i++) nr += 64'(node_st[i]);
        for (int i = 0; i < ne; i++) ni += 64'(st(edge_a[i]) ^ st(edge_b[i]));
        r.infected_total = nr[10:0];
        r.active_edges = ni[12:0];
        wr = nr * 64'(gamma_q);
        total = wr + ni * 64'(alpha_q);
        if (nr == 0 || total == 0) begin
          r.time_step = '1;
        end else begin
          lhs = {64'd0, wr} << 32;
          rhs = {64'd0, total} * {96'd0, c.uniform_event};
          r.has_proposal = 1'b1;
          r.event_kind = !(lhs > rhs);
          if (!r.event_kind) begin
            k = (nr * 64'(c.uniform_pick)) >> 32;
            for (int i = 0; i < nn; i++) begin
              if (node_st[i]) begin
                if (k == 0) begin
                  r.proposed_node = i[9:0];
                  break;
                end
                k--;
              end
            end
          end else begin
            k = (ni * 64'(c.uniform_pick)) >> 32;
            for (int i = 0; i < ne; i++) begin
              if (st(edge_a[i]) ^ st(edge_b[i])) begin
                if (k == 0) begin
                  r.proposed_node = st(edge_a[i]) ? edge_b[i] : edge_a[i];
                  break;
                end
                k--;
              end
            end
          end
          ut = c.uniform_time == 0 ? 32'd1 : c.uniform_time;
          q = neg_ln(ut);
          dt = (q << 8) / total;
          r.time_step = dt > 64'hFFFF_FFFF_FFFF ? '1 : dt[47:0];
        end
      end
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req.ready) begin
      if (req.valid) proposal_queue.push_back(apply_command(cur_cmd));
      if (cmd_queue.size() > 0 && $urandom_range(99) >= src_idle) begin
        cur_cmd = cmd_queue.pop_front();
        req.valid         <= 1'b1;
        req.command       <= cur_cmd.command;
        req.node_index    <= cur_cmd.node_index;
        req.node_infected <= cur_cmd.node_infected;
        req.edge_index    <= cur_cmd.edge_index;
        req.end_first     <= cur_cmd.end_first;
        req.end_second    <= cur_cmd.end_second;
        req.uniform_event <= cur_cmd.uniform_event;
        req.uniform_pick  <= cur_cmd.uniform_pick;
        req.uniform_time  <= cur_cmd.uniform_time;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    proposal_t e;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (proposal_queue.size() == 0) begin
          $error("unexpected result item");
          errors++;
        end else begin
          e = proposal_queue.pop_front();
          check_field("has_proposal", 64'(e.has_proposal), 64'(rsp.has_proposal));
          check_field("event_kind", 64'(e.event_kind), 64'(rsp.event_kind));
          check_field("proposed_node", 64'(e.proposed_node), 64'(rsp.proposed_node));
          check_field("time_step", 64'(e.time_step), 64'(rsp.time_step));
          check_field("infected_total", 64'(e.infected_total), 64'(rsp.infected_total));
          check_field("active_edges", 64'(e.active_edges), 64'(rsp.active_edges));
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= $urandom_range(99) >= snk_idle;
      end
    end
  end

  task automatic cfg_write(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_INFECTION_RATE: alpha_q = val;
      CFG_RECOVERY_RATE:  gamma_q = val;
      CFG_NODE_COUNT:     nodes_cfg = val[10:0];
      default:            edges_cfg = val[12:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (cmd_queue.size() != 0 || req.valid || proposal_queue.size() != 0);
    repeat (5) @(posedge clk);
  endtask

  function automatic sis_cmd_t any_cmd(cmd_t c);
    sis_cmd_t x;
    x.command = c;
    x.node_index = NODE_F_W'($urandom);
    x.node_infected = 1'($urandom);
    x.edge_index = EDGE_F_W'($urandom);
    x.end_first = NODE_F_W'($urandom);
    x.end_second = NODE_F_W'($urandom);
    x.uniform_event = $urandom;
    x.uniform_pick = $urandom;
    x.uniform_time = $urandom;
    return x;
  endfunction

  function automatic sis_cmd_t edge_cmd(int slot, int a, int b);
    sis_cmd_t x;
    x = any_cmd(CMD_WRITE_EDGE);
    x.edge_index = EDGE_F_W'(slot);
    x.end_first = NODE_F_W'(a);
    x.end_second = NODE_F_W'(b);
    return x;
  endfunction

  function automatic sis_cmd_t node_cmd(cmd_t c, int n, bit v);
    sis_cmd_t x;
    x = any_cmd(c);
    x.node_index = NODE_F_W'(n);
    x.node_infected = v;
    return x;
  endfunction

  function automatic sis_cmd_t step_cmd(logic [31:0] ue, logic [31:0] up, logic [31:0] ut);
    sis_cmd_t x;
    x = any_cmd(CMD_STEP);
    x.uniform_event = ue;
    x.uniform_pick = up;
    x.uniform_time = ut;
    return x;
  endfunction

  // mostly nodes in use, edge writes kept inside the already written prefix
  function automatic sis_cmd_t random_cmd(int nn, int written);
    sis_cmd_t x;
    int sel;
    sel = $urandom_range(99);
    if (sel < 35) begin
      x = any_cmd(CMD_STEP);
    end else begin
      x = any_cmd(sel < 55 ? CMD_FLIP : sel < 78 ? CMD_WRITE_NODE : CMD_WRITE_EDGE);
      if ($urandom_range(9) < 8) x.node_index = NODE_F_W'($urandom_range(nn - 1));
      if ($urandom_range(9) < 8) x.end_first = NODE_F_W'($urandom_range(nn - 1));
      if ($urandom_range(9) < 8) x.end_second = NODE_F_W'($urandom_range(nn - 1));
      x.edge_index = EDGE_F_W'($urandom_range(written - 1));
    end
    return x;
  endfunction

  initial begin
    req.valid = 1'b0;
    req.command = CMD_WRITE_EDGE;
    req.node_index = '0;
    req.node_infected = 1'b0;
    req.edge_index = '0;
    req.end_first = '0;
    req.end_second = '0;
    req.uniform_event = '0;
    req.uniform_pick = '0;
    req.uniform_time = '0;
    rsp.ready = 1'b0;
    node_st = '0;
    for (int i = 0; i < DEF_MAX_EDGES; i++) begin
      edge_a[i] = '0;
      edge_b[i] = '0;
    end
    alpha_q = RATE_RESET;
    gamma_q = RATE_RESET;
    nodes_cfg = NODE_COUNT_RESET;
    edges_cfg = EDGE_COUNT_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed, reset settings: no infection, then recovery only
    cmd_queue.push_back(step_cmd(32'd1, 32'd1, 32'd1));
    cmd_queue.push_back(node_cmd(CMD_WRITE_NODE, 1023, 1'b1));
    cmd_queue.push_back(step_cmd(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    cmd_queue.push_back(node_cmd(CMD_FLIP, 0, 1'b0));
    cmd_queue.push_back(step_cmd(32'd0, 32'd0, 32'd0));
    cmd_queue.push_back(node_cmd(CMD_WRITE_NODE, 1023, 1'b0));
    cmd_queue.push_back(node_cmd(CMD_FLIP, 0, 1'b1));
    cmd_queue.push_back(step_cmd(32'h8000_0000, 32'h8000_0000, 32'd1));
    for (int i = 0; i < 32; i++)
      cmd_queue.push_back(edge_cmd(i, i == 0 ? 1023 : $urandom_range(63),
                                   i == 1 ? 1023 : $urandom_range(90)));
    wait_idle();

    // small graph, edges include endpoints beyond the nodes in use
    cfg_write(CFG_NODE_COUNT, 32'd64);
    cfg_write(CFG_EDGE_COUNT, 32'd32);
    cfg_write(CFG_INFECTION_RATE, $urandom);
    cfg_write(CFG_RECOVERY_RATE, $urandom_range(32'h0400_0000));
    for (int i = 0; i < 6; i++) cmd_queue.push_back(node_cmd(CMD_WRITE_NODE, i * 11, 1'b1));
    cmd_queue.push_back(step_cmd(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    cmd_queue.push_back(step_cmd(32'hFFFF_FFFF, 32'd1, 32'd1));
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = ph == 0 ? 20 : ph == 1 ? 52 : 0;
      snk_idle = ph == 0 ? 52 : ph == 1 ? 20 : 0;
      if (ph == 1) begin
        cfg_write(CFG_NODE_COUNT, $urandom_range(1, 64));
        cfg_write(CFG_INFECTION_RATE, $urandom_range(32'h0200_0000));
        cfg_write(CFG_RECOVERY_RATE, $urandom);
      end
      for (int i = 0; i < 13; i++) cmd_queue.push_back(random_cmd(64, 32));
      if (ph == 0) hold_req = 1'b1;
      wait_idle();
    end

    // rate extremes
    cfg_write(CFG_NODE_COUNT, 32'd64);
    cfg_write(CFG_INFECTION_RATE, 32'd0);
    cfg_write(CFG_RECOVERY_RATE, 32'd0);
    cmd_queue.push_back(step_cmd($urandom, $urandom, $urandom));
    wait_idle();
    cfg_write(CFG_INFECTION_RATE, 32'hFFFF_FFFF);
    cmd_queue.push_back(step_cmd($urandom, $urandom, 32'hFFFF_FFFF));
    cmd_queue.push_back(step_cmd($urandom, $urandom, $urandom));
    wait_idle();
    cfg_write(CFG_RECOVERY_RATE, 32'hFFFF_FFFF);
    cfg_write(CFG_INFECTION_RATE, 32'd1);
    cmd_queue.push_back(step_cmd($urandom, $urandom, 32'd1));
    cmd_queue.push_back(step_cmd(32'hFFFF_FFFF, $urandom, $urandom));
    wait_idle();

    // single node, no edges
    cfg_write(CFG_NODE_COUNT, 32'd1);
    cfg_write(CFG_EDGE_COUNT, 32'd0);
    cmd_queue.push_back(step_cmd($urandom, $urandom, $urandom));
    cmd_queue.push_back(node_cmd(CMD_FLIP, 0, 1'b0));
    cmd_queue.push_back(step_cmd($urandom, $urandom, $urandom));
    wait_idle();

    // whole node table, node count above capacity is clamped
    cfg_write(CFG_RECOVERY_RATE, $urandom_range(32'h0100_0000));
    cfg_write(CFG_INFECTION_RATE, $urandom_range(32'h0400_0000));
    cfg_write(CFG_EDGE_COUNT, 32'd32);
    for (int i = 0; i < 10; i++)
      cmd_queue.push_back(node_cmd(CMD_FLIP, $urandom_range(1023), 1'b0));
    wait_idle();
    cfg_write(CFG_NODE_COUNT, 32'h7FF);
    for (int i = 0; i < 3; i++) cmd_queue.push_back(step_cmd($urandom, $urandom, $urandom));
    cmd_queue.push_back(step_cmd(32'd1, 32'hFFFF_FFFF, $urandom));
    cmd_queue.push_back(step_cmd(32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom));
    wait_idle();
    cfg_write(CFG_NODE_COUNT, 32'd1024);
    cmd_queue.push_back(step_cmd($urandom, $urandom, $urandom));
    wait_idle();

    repeat (200) @(posedge clk);
    if (errors == 0 && proposal_queue.size() == 0) begin
      $display("sis_network_gillespie_step: match");
    end else begin
      if (proposal_queue.size() != 0) $error("%0d results missing", proposal_queue.size());
      $display("sis_network_gillespie_step: mismatch");
    end
    $finish;
  end

  initial begin
    #15ms;
    $display("sis_network_gillespie_step: mismatch");
    $finish;
  end

endmodule
